### rtl/core/lattice_rod_monte_carlo_step_defines.svh
// Assertion macros shared by the lattice rod Monte Carlo step RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LATTICE_ROD_MONTE_CARLO_STEP_DEFINES_SVH
`define LATTICE_ROD_MONTE_CARLO_STEP_DEFINES_SVH

`ifndef SYNTHESIS
`define LRMC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LRMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRMC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define LRMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/lrmc_pkg.sv
// Package for the lattice rod Monte Carlo step: transaction structs, codes, constants.
// No dependencies.
package lrmc_pkg;

    localparam int COORD_W      = 6;
    localparam int LATTICE_SIZE = 2 ** COORD_W;
    localparam int FRAC_W       = 16;
    localparam int Z_W          = 16;
    localparam int TOTAL_W      = 10;

    typedef enum logic [2:0] {
        OUT_REJECT   = 3'd0,
        OUT_INSERTED = 3'd1,
        OUT_BLOCKED  = 3'd2,
        OUT_REMOVED  = 3'd3,
        OUT_EMPTY    = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_ROTATE = 2'd1,
        CELL_LOAD   = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic               action;
        logic               is_horizontal;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [FRAC_W-1:0]  accept_fraction;
        logic [FRAC_W-1:0]  pick_fraction;
    } req_t;

    typedef struct packed {
        outcome_t           outcome;
        logic [TOTAL_W-1:0] horizontal_total;
        logic [TOTAL_W-1:0] vertical_total;
        logic [COORD_W-1:0] removed_x;
        logic [COORD_W-1:0] removed_y;
        logic               removed_horizontal;
    } rsp_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               horiz;
    } rod_t;

endpackage

### rtl/core/lrmc_grid.sv
// Occupancy grid: one row of LATTICE_SIZE bits per x, registered read, per-row valid bits.
// Depends on lrmc_pkg.
module lrmc_grid (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rd_en,
    input  logic [lrmc_pkg::COORD_W-1:0]         rd_row,
    output logic [lrmc_pkg::LATTICE_SIZE-1:0]    rd_data,
    input  logic                                 wr_en,
    input  logic [lrmc_pkg::COORD_W-1:0]         wr_row,
    input  logic [lrmc_pkg::LATTICE_SIZE-1:0]    wr_data
);
    import lrmc_pkg::*;

    logic [LATTICE_SIZE-1:0] mem [LATTICE_SIZE];
    logic [LATTICE_SIZE-1:0] row_valid_reg;
    logic                    rd_valid_reg;
    logic [LATTICE_SIZE-1:0] rd_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_row] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_row];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_row];
        end
    end

    // never-written rows read as empty
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

### rtl/core/lrmc_cell.sv
// One slot of the rod list chain: holds one rod, takes its neighbor, the head or a new rod.
// Depends on lrmc_pkg.
module lrmc_cell #(
    parameter int INDEX_W = 10,
    parameter int INDEX   = 0
) (
    input  logic                   clk,
    input  lrmc_pkg::cell_op_t     op,
    input  logic [INDEX_W-1:0]     last_idx,
    input  lrmc_pkg::rod_t         next_entry,
    input  lrmc_pkg::rod_t         head_entry,
    input  lrmc_pkg::rod_t         load_entry,
    output lrmc_pkg::rod_t         entry
);
    import lrmc_pkg::*;

    localparam logic [INDEX_W-1:0] MY_IDX = INDEX_W'(INDEX);

    rod_t entry_reg;
    rod_t entry_next;
    logic is_last;

    assign is_last = (last_idx == MY_IDX);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (op)
            CELL_ROTATE: entry_next = is_last ? head_entry : next_entry;
            CELL_LOAD:
            begin
                if (is_last)
                begin
                    entry_next = load_entry;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### rtl/core/lattice_rod_monte_carlo_step.sv
// Grand canonical Monte Carlo step for hard rods on a periodic 64x64 lattice, one move per
// transaction, one result each. An insertion reads and checks each covered cell of the
// occupancy grid, then reads and writes each one; a deletion makes one full rotation of the
// rod list chain that pulls the chosen rod out and closes the gap, then clears the rod's
// covered cells on the occupancy grid.
module lattice_rod_monte_carlo_step #(
    parameter int ROD_LENGTH = 8,
    parameter int MAX_RODS   = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  lrmc_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output lrmc_pkg::rsp_t               rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lrmc_pkg::Z_W-1:0]     cfg_data
);
    import lrmc_pkg::*;

`include "lattice_rod_monte_carlo_step_defines.svh"

    localparam int CNT_W   = $clog2(MAX_RODS + 2);
    localparam int K_W     = (ROD_LENGTH > 1) ? $clog2(ROD_LENGTH) : 1;
    localparam int PN_W    = FRAC_W + CNT_W;
    localparam int PD_W    = FRAC_W + Z_W;
    localparam longint INS_SCALE = 32 * LATTICE_SIZE * LATTICE_SIZE;
    localparam longint DEL_SCALE = 2 * LATTICE_SIZE * LATTICE_SIZE;
    localparam logic [K_W-1:0]   K_LAST   = K_W'(ROD_LENGTH - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_RODS);
    localparam logic [15:0]      Z_RESET  = 16'd2294;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL    = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_CHK_RD = 9'b000001000,
        S_CHK_WT = 9'b000010000,
        S_PNT_RD = 9'b000100000,
        S_PNT_WR = 9'b001000000,
        S_ROT    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [Z_W-1:0]    z_reg;
    req_t              req_reg;
    logic [CNT_W-1:0]  h_cnt_reg, h_cnt_next;
    logic [CNT_W-1:0]  v_cnt_reg, v_cnt_next;
    logic [CNT_W-1:0]  n_cnt;
    logic [PN_W-1:0]   prod_ins_reg;
    logic [PD_W-1:0]   prod_del_reg;
    logic [PN_W-1:0]   prod_pick_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  rot_cnt_reg, rot_cnt_next;
    logic [K_W-1:0]    k_reg, k_next;
    rod_t              cur_reg, cur_next;
    logic              set_reg, set_next;
    outcome_t          outcome_reg, outcome_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              ins_ok;
    logic              del_ok;
    logic [COORD_W-1:0] step_row;
    logic [COORD_W-1:0] step_bit;
    logic [LATTICE_SIZE-1:0] grid_rd_data;
    logic [LATTICE_SIZE-1:0] grid_wr_data;
    logic              grid_rd_en;
    logic              grid_wr_en;
    cell_op_t          cell_op;
    logic [CNT_W-1:0]  cell_last;
    rod_t              new_rod;
    rod_t              cell_entry [MAX_RODS];
    logic [31:0]       h_wide;
    logic [31:0]       v_wide;
    logic [CNT_W:0]    n_sum;

    assign n_sum = {1'b0, h_cnt_reg} + {1'b0, v_cnt_reg};
    assign n_cnt = n_sum[CNT_W-1:0];

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ins_ok = (64'(prod_ins_reg) <= 64'(z_reg) * 64'(INS_SCALE));
    assign del_ok = (64'(prod_del_reg) * 64'(DEL_SCALE) <= (64'(n_cnt) << 28));

    assign step_row = cur_reg.horiz ? COORD_W'(cur_reg.x + k_reg) : cur_reg.x;
    assign step_bit = cur_reg.horiz ? cur_reg.y : COORD_W'(cur_reg.y + k_reg);

    assign grid_rd_en = (state_reg == S_CHK_RD) || (state_reg == S_PNT_RD);
    assign grid_wr_en = (state_reg == S_PNT_WR);

    always_comb
    begin
        grid_wr_data           = grid_rd_data;
        grid_wr_data[step_bit] = set_reg;
    end

    lrmc_grid u_grid (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (grid_rd_en),
        .rd_row  (step_row),
        .rd_data (grid_rd_data),
        .wr_en   (grid_wr_en),
        .wr_row  (step_row),
        .wr_data (grid_wr_data)
    );

    // rod list chain
    always_comb
    begin
        cell_op   = CELL_HOLD;
        cell_last = n_cnt;
        if (state_reg == S_ROT)
        begin
            cell_op   = CELL_ROTATE;
            cell_last = (rot_cnt_reg <= idx_reg) ? CNT_W'(n_cnt - 1'b1)
                                                 : CNT_W'(n_cnt - 2'd2);
        end
        else if ((state_reg == S_PNT_WR) && (k_reg == K_LAST) && set_reg)
        begin
            cell_op = CELL_LOAD;
        end
    end

    assign new_rod = cur_reg;

    for (genvar i = 0; i < MAX_RODS; i++)
    begin : g_cell
        lrmc_cell #(
            .INDEX_W (CNT_W),
            .INDEX   (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .last_idx   (cell_last),
            .next_entry (cell_entry[(i + 1) % MAX_RODS]),
            .head_entry (cell_entry[0]),
            .load_entry (new_rod),
            .entry      (cell_entry[i])
        );
    end

    assign h_wide = 32'(h_cnt_reg);
    assign v_wide = 32'(v_cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        h_cnt_next     = h_cnt_reg;
        v_cnt_next     = v_cnt_reg;
        idx_next       = idx_reg;
        rot_cnt_next   = rot_cnt_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        set_next       = set_reg;
        outcome_next   = outcome_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next   = S_DONE;
                outcome_next = OUT_REJECT;
                if (!req_reg.action)
                begin
                    if (ins_ok)
                    begin
                        if (n_cnt >= MAX_CNT)
                        begin
                            outcome_next = OUT_BLOCKED;
                        end
                        else
                        begin
                            cur_next   = '{x: req_reg.cell_x, y: req_reg.cell_y,
                                           horiz: req_reg.is_horizontal};
                            k_next     = '0;
                            state_next = S_CHK_RD;
                        end
                    end
                end
                else if (del_ok)
                begin
                    if (n_cnt == '0)
                    begin
                        outcome_next = OUT_EMPTY;
                    end
                    else
                    begin
                        idx_next     = prod_pick_reg[FRAC_W +: CNT_W];
                        rot_cnt_next = '0;
                        state_next   = S_ROT;
                    end
                end
            end
            S_CHK_RD:
            begin
                state_next = S_CHK_WT;
            end
            S_CHK_WT:
            begin
                if (grid_rd_data[step_bit])
                begin
                    outcome_next = OUT_BLOCKED;
                    state_next   = S_DONE;
                end
                else if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    set_next   = 1'b1;
                    state_next = S_PNT_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_CHK_RD;
                end
            end
            S_PNT_RD:
            begin
                state_next = S_PNT_WR;
            end
            S_PNT_WR:
            begin
                if (k_reg == K_LAST)
                begin
                    state_next = S_DONE;
                    if (set_reg)
                    begin
                        outcome_next = OUT_INSERTED;
                        if (cur_reg.horiz)
                        begin
                            h_cnt_next = h_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            v_cnt_next = v_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        outcome_next = OUT_REMOVED;
                        if (cur_reg.horiz)
                        begin
                            h_cnt_next = h_cnt_reg - 1'b1;
                        end
                        else
                        begin
                            v_cnt_next = v_cnt_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_PNT_RD;
                end
            end
            S_ROT:
            begin
                if (rot_cnt_reg == idx_reg)
                begin
                    cur_next = cell_entry[0];
                end
                if (rot_cnt_reg == CNT_W'(n_cnt - 1'b1))
                begin
                    k_next     = '0;
                    set_next   = 1'b0;
                    state_next = S_PNT_RD;
                end
                else
                begin
                    rot_cnt_next = rot_cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.outcome          = outcome_reg;
                    rsp_next.horizontal_total = h_wide[TOTAL_W-1:0];
                    rsp_next.vertical_total   = v_wide[TOTAL_W-1:0];
                    if (outcome_reg == OUT_REMOVED)
                    begin
                        rsp_next.removed_x          = cur_reg.x;
                        rsp_next.removed_y          = cur_reg.y;
                        rsp_next.removed_horizontal = cur_reg.horiz;
                    end
                    else
                    begin
                        rsp_next.removed_x          = '0;
                        rsp_next.removed_y          = '0;
                        rsp_next.removed_horizontal = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            z_reg         <= Z_RESET;
            h_cnt_reg     <= '0;
            v_cnt_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_cnt_reg     <= h_cnt_next;
            v_cnt_reg     <= v_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                z_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            req_reg <= req;
        end
        prod_ins_reg  <= PN_W'(req_reg.accept_fraction * (CNT_W'(n_cnt) + 1'b1));
        prod_del_reg  <= req_reg.accept_fraction * z_reg;
        prod_pick_reg <= PN_W'(req_reg.pick_fraction * n_cnt);
        idx_reg       <= idx_next;
        rot_cnt_reg   <= rot_cnt_next;
        k_reg         <= k_next;
        cur_reg       <= cur_next;
        set_reg       <= set_next;
        outcome_reg   <= outcome_next;
        rsp_reg       <= rsp_next;
    end

    `LRMC_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, n_sum <= (CNT_W + 1)'(MAX_RODS),
        "rod count exceeds list capacity")
    `LRMC_ASSERT_IMPLY(a_rot_range, clk, rst_n, state_reg == S_ROT,
        (rot_cnt_reg < n_cnt) && (idx_reg < n_cnt), "rotation past list end")
    `LRMC_ASSERT_NEXT(a_rot_exit, clk, rst_n, state_reg == S_ROT,
        (state_reg == S_ROT) || (state_reg == S_PNT_RD), "rotation left to wrong state")
    `LRMC_ASSERT_IMPLY(a_rsp_removed, clk, rst_n,
        rsp_valid_reg && (rsp_reg.outcome != OUT_REMOVED),
        (rsp_reg.removed_x == '0) && (rsp_reg.removed_y == '0)
        && !rsp_reg.removed_horizontal, "removed fields set without removal")

endmodule
